[src/fds_pkg.sv]
// Shared types and constants for the face depth sorter.
// Holds request codes, register indexes, the sequencer states and field widths.
// No dependencies.
package fds_pkg;

  // Default store depths
  localparam int VERTEX_DEPTH_DEF = 1024;
  localparam int FACE_DEPTH_DEF   = 1024;

  // Field widths
  localparam int COORD_W   = 16;
  localparam int IDX_W     = 10;
  localparam int KEY_W     = 36;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 32;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FETCH = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Z = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_SQ,
    S_ADD_SUM,
    S_ADD_WR,
    S_FET_SCAN,
    S_FET_MARK,
    S_FET_OUT
  } state_t;

  // Control of the shared square-accumulate unit
  typedef struct packed {
    logic clr;
    logic step;
  } sq_ctl_t;

endpackage

[src/fds_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds when not reading
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/fds_sq_acc.sv]
// Shared square-and-accumulate unit: squares one coordinate difference per step
// and sums the squares into a face key. Depends on fds_pkg.
module fds_sq_acc
  import fds_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  sq_ctl_t                  ctl,
  input  logic signed [DIFF_W-1:0] diff,
  output logic [KEY_W-1:0]         key
);

  logic signed [2*DIFF_W-1:0] sq;
  logic [SQ_W-1:0]            prod_r;
  logic                       pvld_r;
  logic [KEY_W-1:0]           acc_r;

  // Square fits in 32 bits: |diff| is at most 65535
  assign sq = diff * diff;

  // Track which cycle holds a fresh product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= ctl.step;
    end
  end

  // Register the product, then accumulate it
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      prod_r <= sq[SQ_W-1:0];
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (pvld_r) begin
      acc_r <= acc_r + KEY_W'(prod_r);
    end
  end

  assign key = acc_r;

endmodule

[src/face_depth_sorter.sv]
// Face depth sorter top level: back-to-front face ordering for a painter's pass.
// Depends on fds_pkg, fds_ram and fds_sq_acc.
// Usage:
//   Requests enter on the in_ channel (valid/stall). A vertex load writes one
//   vertex slot, an add face computes the face key (sum of squared corner
//   distances to the camera) and stores the face, a clear drops all faces.
//   A fetch returns on the out_ channel the unreturned face with the largest
//   key (ties in arrival order), or a result with none_left set.
//   Camera registers are written on the cfg_ port (always ready); the user
//   must write them only while idle, the block itself does not enforce it.
// Timing:
//   Load and clear complete in the idle state. An add does per corner one vertex
//   read and three passes through the single shared multiplier. A fetch scans
//   the key memory, one stored key per cycle through its single read port.
//   in_stall stays high while a request is in progress.
// Reset:
//   Clears face counts, camera and handshake state. No memory sweep is needed;
//   every face slot below the face count was written when it was added.
// Stall: a result waits in the output register; a following fetch holds in its
//   last cycle until that register frees up.
module face_depth_sorter
  import fds_pkg::*;
#(
  parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF,
  parameter int FACE_DEPTH   = FACE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Request channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [REQ_W-1:0]           in_req_type,
  input  logic [IDX_W-1:0]           in_vertex_slot,
  input  logic signed [COORD_W-1:0]  in_pos_x,
  input  logic signed [COORD_W-1:0]  in_pos_y,
  input  logic signed [COORD_W-1:0]  in_pos_z,
  input  logic [IDX_W-1:0]           in_corner_a,
  input  logic [IDX_W-1:0]           in_corner_b,
  input  logic [IDX_W-1:0]           in_corner_c,
  // Result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [IDX_W-1:0]           out_face_number,
  output logic [IDX_W-1:0]           out_corner_a,
  output logic [IDX_W-1:0]           out_corner_b,
  output logic [IDX_W-1:0]           out_corner_c,
  output logic [KEY_W-1:0]           out_distance_key,
  output logic                       out_is_final,
  output logic                       out_none_left,
  // Configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COORD_W-1:0]         cfg_data
);

  localparam int VAW   = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int FAW   = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;
  localparam int FCW   = $clog2(FACE_DEPTH + 1);
  localparam int RNG_W = 17;
  localparam int VTX_W = 3 * COORD_W;
  localparam int CRN_W = 3 * IDX_W;

  state_t state_r, state_nxt;

  logic [COORD_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic [FCW-1:0]     face_total_r, face_total_nxt;
  logic [FCW-1:0]     ret_total_r, ret_total_nxt;
  logic [1:0]         corner_r, corner_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic               oob_r, oob_nxt;
  logic [IDX_W-1:0]   ca_r, ca_nxt, cb_r, cb_nxt, cc_r, cc_nxt;
  logic [FCW-1:0]     iss_r, iss_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [FAW-1:0]     rd_idx_r, rd_idx_nxt;
  logic               found_r, found_nxt;
  logic [FAW-1:0]     best_idx_r, best_idx_nxt;
  logic [KEY_W-1:0]   best_key_r, best_key_nxt;

  logic               out_vld_r;
  logic [IDX_W-1:0]   out_num_r, out_ca_r, out_cb_r, out_cc_r;
  logic [KEY_W-1:0]   out_key_r;
  logic               out_fin_r, out_none_r;
  logic               out_load;

  // Memory ports
  logic             vtx_we, vtx_re;
  logic [VAW-1:0]   vtx_waddr, vtx_raddr;
  logic [VTX_W-1:0] vtx_wdata, vtx_rdata;
  logic             key_we, key_re;
  logic [FAW-1:0]   key_waddr, key_raddr;
  logic [KEY_W:0]   key_wdata, key_rdata;
  logic             crn_we, crn_re;
  logic [FAW-1:0]   crn_waddr, crn_raddr;
  logic [CRN_W-1:0] crn_wdata, crn_rdata;

  // Shared unit
  sq_ctl_t                  sq_ctl;
  logic signed [DIFF_W-1:0] diff;
  logic [KEY_W-1:0]         sq_key;
  logic [COORD_W-1:0]       coord, cam;
  logic [IDX_W-1:0]         cidx;
  logic                     cidx_ok;

  fds_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_DEPTH)) u_vtx_ram (
    .clk(clk), .we(vtx_we), .waddr(vtx_waddr), .wdata(vtx_wdata),
    .re(vtx_re), .raddr(vtx_raddr), .rdata(vtx_rdata)
  );

  fds_ram #(.WIDTH(KEY_W + 1), .DEPTH(FACE_DEPTH)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .re(key_re), .raddr(key_raddr), .rdata(key_rdata)
  );

  fds_ram #(.WIDTH(CRN_W), .DEPTH(FACE_DEPTH)) u_crn_ram (
    .clk(clk), .we(crn_we), .waddr(crn_waddr), .wdata(crn_wdata),
    .re(crn_re), .raddr(crn_raddr), .rdata(crn_rdata)
  );

  fds_sq_acc u_sq_acc (
    .clk(clk), .rst_n(rst_n), .ctl(sq_ctl), .diff(diff), .key(sq_key)
  );

  // Select the current corner and check it against the vertex store
  always_comb begin
    case (corner_r)
      2'd0:    cidx = ca_r;
      2'd1:    cidx = cb_r;
      default: cidx = cc_r;
    endcase
  end
  assign cidx_ok = RNG_W'(cidx) < RNG_W'(VERTEX_DEPTH);

  // Pick coordinate and camera axis; out-of-store corners read as the origin
  always_comb begin
    case (axis_r)
      2'd0: begin
        coord = vtx_rdata[3*COORD_W-1:2*COORD_W];
        cam   = cam_x_r;
      end
      2'd1: begin
        coord = vtx_rdata[2*COORD_W-1:COORD_W];
        cam   = cam_y_r;
      end
      default: begin
        coord = vtx_rdata[COORD_W-1:0];
        cam   = cam_z_r;
      end
    endcase
    if (oob_r) begin
      coord = '0;
    end
  end
  assign diff = $signed({coord[COORD_W-1], coord}) - $signed({cam[COORD_W-1], cam});

  // Sequencer: next state and memory controls
  always_comb begin
    state_nxt      = state_r;
    face_total_nxt = face_total_r;
    ret_total_nxt  = ret_total_r;
    corner_nxt     = corner_r;
    axis_nxt       = axis_r;
    oob_nxt        = oob_r;
    ca_nxt         = ca_r;
    cb_nxt         = cb_r;
    cc_nxt         = cc_r;
    iss_nxt        = iss_r;
    rd_vld_nxt     = rd_vld_r;
    rd_idx_nxt     = rd_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_key_nxt   = best_key_r;

    vtx_we    = 1'b0;
    vtx_waddr = VAW'(in_vertex_slot);
    vtx_wdata = {in_pos_x, in_pos_y, in_pos_z};
    vtx_re    = 1'b0;
    vtx_raddr = VAW'(cidx);
    key_we    = 1'b0;
    key_waddr = FAW'(face_total_r);
    key_wdata = {1'b0, sq_key};
    key_re    = 1'b0;
    key_raddr = FAW'(iss_r);
    crn_we    = 1'b0;
    crn_waddr = FAW'(face_total_r);
    crn_wdata = {ca_r, cb_r, cc_r};
    crn_re    = 1'b0;
    crn_raddr = best_idx_r;
    sq_ctl    = '0;
    out_load  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            REQ_LOAD: begin
              vtx_we = RNG_W'(in_vertex_slot) < RNG_W'(VERTEX_DEPTH);
            end
            REQ_ADD: begin
              // Drop the face when the store is full
              if (face_total_r < FCW'(FACE_DEPTH)) begin
                ca_nxt     = in_corner_a;
                cb_nxt     = in_corner_b;
                cc_nxt     = in_corner_c;
                corner_nxt = 2'd0;
                sq_ctl.clr = 1'b1;
                state_nxt  = S_ADD_RD;
              end
            end
            REQ_FETCH: begin
              iss_nxt    = '0;
              rd_vld_nxt = 1'b0;
              found_nxt  = 1'b0;
              state_nxt  = S_FET_SCAN;
            end
            REQ_CLEAR: begin
              face_total_nxt = '0;
              ret_total_nxt  = '0;
            end
            default: ;
          endcase
        end
      end

      // Read one corner's vertex
      S_ADD_RD: begin
        vtx_re    = cidx_ok;
        oob_nxt   = !cidx_ok;
        axis_nxt  = 2'd0;
        state_nxt = S_ADD_SQ;
      end

      // Square one axis difference per cycle
      S_ADD_SQ: begin
        sq_ctl.step = 1'b1;
        axis_nxt    = axis_r + 2'd1;
        if (axis_r == 2'd2) begin
          if (corner_r == 2'd2) begin
            state_nxt = S_ADD_SUM;
          end else begin
            corner_nxt = corner_r + 2'd1;
            state_nxt  = S_ADD_RD;
          end
        end
      end

      // Let the last product drain into the sum
      S_ADD_SUM: begin
        state_nxt = S_ADD_WR;
      end

      // Store the new face, not yet returned
      S_ADD_WR: begin
        key_we         = 1'b1;
        crn_we         = 1'b1;
        face_total_nxt = face_total_r + FCW'(1);
        state_nxt      = S_IDLE;
      end

      // Stream keys and keep the first largest unreturned one
      S_FET_SCAN: begin
        if (iss_r != face_total_r) begin
          key_re  = 1'b1;
          iss_nxt = iss_r + FCW'(1);
        end
        rd_vld_nxt = key_re;
        rd_idx_nxt = FAW'(iss_r);
        if (rd_vld_r && !key_rdata[KEY_W] &&
            (!found_r || key_rdata[KEY_W-1:0] > best_key_r)) begin
          found_nxt    = 1'b1;
          best_idx_nxt = rd_idx_r;
          best_key_nxt = key_rdata[KEY_W-1:0];
        end
        if (iss_r == face_total_r && !rd_vld_r) begin
          state_nxt = S_FET_MARK;
        end
      end

      // Mark the winner returned and fetch its corners
      S_FET_MARK: begin
        if (found_r) begin
          key_we        = 1'b1;
          key_waddr     = best_idx_r;
          key_wdata     = {1'b1, best_key_r};
          crn_re        = 1'b1;
          ret_total_nxt = ret_total_r + FCW'(1);
        end
        state_nxt = S_FET_OUT;
      end

      // Hold until the output register is free
      S_FET_OUT: begin
        if (!out_vld_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      face_total_r <= '0;
      ret_total_r  <= '0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      face_total_r <= face_total_nxt;
      ret_total_r  <= ret_total_nxt;
      rd_vld_r     <= rd_vld_nxt;
      found_r      <= found_nxt;
    end
  end

  // Working registers of the sequencer
  always_ff @(posedge clk) begin
    corner_r   <= corner_nxt;
    axis_r     <= axis_nxt;
    oob_r      <= oob_nxt;
    ca_r       <= ca_nxt;
    cb_r       <= cb_nxt;
    cc_r       <= cc_nxt;
    iss_r      <= iss_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_key_r <= best_key_nxt;
  end

  // Camera registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAM_X: cam_x_r <= cfg_data;
        CFG_CAM_Y: cam_y_r <= cfg_data;
        CFG_CAM_Z: cam_z_r <= cfg_data;
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  // Output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  // Output register: payload, zeros when nothing was left
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (found_r) begin
        out_num_r  <= IDX_W'(best_idx_r);
        out_ca_r   <= crn_rdata[3*IDX_W-1:2*IDX_W];
        out_cb_r   <= crn_rdata[2*IDX_W-1:IDX_W];
        out_cc_r   <= crn_rdata[IDX_W-1:0];
        out_key_r  <= best_key_r;
        out_fin_r  <= ret_total_r >= face_total_r;
        out_none_r <= 1'b0;
      end else begin
        out_num_r  <= '0;
        out_ca_r   <= '0;
        out_cb_r   <= '0;
        out_cc_r   <= '0;
        out_key_r  <= '0;
        out_fin_r  <= 1'b0;
        out_none_r <= 1'b1;
      end
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_vld_r;
  assign out_face_number  = out_num_r;
  assign out_corner_a     = out_ca_r;
  assign out_corner_b     = out_cb_r;
  assign out_corner_c     = out_cc_r;
  assign out_distance_key = out_key_r;
  assign out_is_final     = out_fin_r;
  assign out_none_left    = out_none_r;

`ifndef SYNTHESIS
  // Never more faces returned than stored
  a_ret_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    ret_total_r <= face_total_r)
    else $error("returned count exceeds face count");

  // Face count stays within the store
  a_total_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    face_total_r <= FCW'(FACE_DEPTH))
    else $error("face count exceeds store depth");

  // A found face bumps the returned count by one
  a_mark_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FET_MARK && found_r) |=>
      ret_total_r == FCW'($past(ret_total_r) + FCW'(1)))
    else $error("returned count not advanced on mark");

  // Scanned keys come only from stored faces
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> FCW'(rd_idx_r) < face_total_r)
    else $error("scan read beyond face count");

  // An empty fetch result carries no face
  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_none_left) |-> (!out_is_final && out_distance_key == '0))
    else $error("empty fetch result carries face data");
`endif

endmodule

[sim/face_depth_sorter_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for face_depth_sorter: directed request table, then random traffic.
// Depends on fds_pkg and the face_depth_sorter RTL; responses are checked by a predictor.
module face_depth_sorter_tb;
  import fds_pkg::*;

  // One request on the input channel
  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [IDX_W-1:0]   slot;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [IDX_W-1:0]   a;
    logic [IDX_W-1:0]   b;
    logic [IDX_W-1:0]   c;
  } depth_req_t;

  // One returned face on the result channel
  typedef struct packed {
    logic [IDX_W-1:0] face_number;
    logic [IDX_W-1:0] corner_a;
    logic [IDX_W-1:0] corner_b;
    logic [IDX_W-1:0] corner_c;
    logic [KEY_W-1:0] key;
    logic             is_final;
    logic             none_left;
  } face_result_t;

  // Directed row: request, and a hand-written response where one is given
  typedef struct packed {
    depth_req_t   rq;
    logic         typed;
    face_result_t want;
  } script_row_t;

  localparam int SCRIPT_ROWS = 25;
  localparam face_result_t NONE_LEFT = '{10'd0, 10'd0, 10'd0, 10'd0, 36'd0, 1'b0, 1'b1};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [REQ_W-1:0]   in_req_type = REQ_LOAD;
  logic [IDX_W-1:0]   in_vertex_slot = '0;
  logic [COORD_W-1:0] in_pos_x = '0;
  logic [COORD_W-1:0] in_pos_y = '0;
  logic [COORD_W-1:0] in_pos_z = '0;
  logic [IDX_W-1:0]   in_corner_a = '0;
  logic [IDX_W-1:0]   in_corner_b = '0;
  logic [IDX_W-1:0]   in_corner_c = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [IDX_W-1:0]   out_face_number;
  logic [IDX_W-1:0]   out_corner_a;
  logic [IDX_W-1:0]   out_corner_b;
  logic [IDX_W-1:0]   out_corner_c;
  logic [KEY_W-1:0]   out_distance_key;
  logic               out_is_final;
  logic               out_none_left;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CAM_X;
  logic [COORD_W-1:0]   cfg_data = '0;

  // Sorter shadow state
  logic signed [COORD_W-1:0] cam_x, cam_y, cam_z;
  logic signed [COORD_W-1:0] vert_x [VERTEX_DEPTH_DEF];
  logic signed [COORD_W-1:0] vert_y [VERTEX_DEPTH_DEF];
  logic signed [COORD_W-1:0] vert_z [VERTEX_DEPTH_DEF];
  bit                        vert_seen [VERTEX_DEPTH_DEF];
  logic [IDX_W-1:0]          vert_slots [$];
  logic [IDX_W-1:0]          tri_a [FACE_DEPTH_DEF];
  logic [IDX_W-1:0]          tri_b [FACE_DEPTH_DEF];
  logic [IDX_W-1:0]          tri_c [FACE_DEPTH_DEF];
  logic [KEY_W-1:0]          tri_key [FACE_DEPTH_DEF];
  bit                        tri_done [FACE_DEPTH_DEF];
  int                        tri_count = 0;
  int                        done_count = 0;

  face_result_t due_faces [$];
  int           mismatch_count = 0;
  int           send_gap_pct = 13;
  int           stall_pct = 57;

  // Directed requests; camera is still at its reset position here
  script_row_t script [SCRIPT_ROWS] = '{
    '{'{REQ_FETCH, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b1, NONE_LEFT},
    '{'{REQ_LOAD, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{REQ_LOAD, 10'd1023, 16'h7FFF, 16'h7FFF, 16'h7FFF, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{REQ_LOAD, 10'd1, 16'h8000, 16'h8000, 16'h8000, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{REQ_LOAD, 10'd682, 16'h5555, 16'hAAAA, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{REQ_LOAD, 10'd341, 16'h0001, 16'hFFFF, 16'h0064, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{REQ_ADD, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{REQ_ADD, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd1023, 10'd1023, 10'd1023}, 1'b0, '0},
    '{'{REQ_ADD, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd1, 10'd1, 10'd1}, 1'b0, '0},
    '{'{REQ_ADD, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{REQ_ADD, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd341, 10'd682, 10'd0}, 1'b0, '0},
    '{'{REQ_FETCH, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b1,
      '{10'd2, 10'd1, 10'd1, 10'd1, 36'd9663676416, 1'b0, 1'b0}},
    '{'{REQ_FETCH, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b1,
      '{10'd1, 10'd1023, 10'd1023, 10'd1023, 36'd9663086601, 1'b0, 1'b0}},
    '{'{REQ_FETCH, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{REQ_FETCH, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b1,
      '{10'd0, 10'd0, 10'd0, 10'd0, 36'd0, 1'b0, 1'b0}},
    '{'{REQ_FETCH, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b1,
      '{10'd3, 10'd0, 10'd0, 10'd0, 36'd0, 1'b1, 1'b0}},
    '{'{REQ_FETCH, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b1, NONE_LEFT},
    '{'{REQ_ADD, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd1023, 10'd0, 10'd1}, 1'b0, '0},
    '{'{REQ_CLEAR, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{REQ_FETCH, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b1, NONE_LEFT},
    '{'{REQ_ADD, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd682, 10'd341, 10'd1023}, 1'b0, '0},
    '{'{REQ_ADD, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd1023, 10'd0, 10'd1}, 1'b0, '0},
    '{'{REQ_FETCH, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{REQ_FETCH, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b0, '0},
    '{'{REQ_CLEAR, 10'd0, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0}, 1'b0, '0}
  };

  face_depth_sorter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_vertex_slot   (in_vertex_slot),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_corner_a      (in_corner_a),
    .in_corner_b      (in_corner_b),
    .in_corner_c      (in_corner_c),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_face_number  (out_face_number),
    .out_corner_a     (out_corner_a),
    .out_corner_b     (out_corner_b),
    .out_corner_c     (out_corner_c),
    .out_distance_key (out_distance_key),
    .out_is_final     (out_is_final),
    .out_none_left    (out_none_left),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic flag(input string msg);
    mismatch_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Squared distance of one corner to the camera
  function automatic logic [KEY_W-1:0] corner_dist(input logic [IDX_W-1:0] idx);
    longint dx, dy, dz;
    dx = longint'(vert_x[idx]) - longint'(cam_x);
    dy = longint'(vert_y[idx]) - longint'(cam_y);
    dz = longint'(vert_z[idx]) - longint'(cam_z);
    return KEY_W'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Advance the sorter shadow by one request; report the face it returns
  task automatic sort_step(input depth_req_t r, output bit gives, output face_result_t res);
    int pick;
    gives = 1'b0;
    res = '0;
    pick = -1;
    case (r.kind)
      REQ_LOAD: begin
        vert_x[r.slot] = r.x;
        vert_y[r.slot] = r.y;
        vert_z[r.slot] = r.z;
        if (!vert_seen[r.slot]) begin
          vert_seen[r.slot] = 1'b1;
          vert_slots.push_back(r.slot);
        end
      end
      REQ_ADD: begin
        // drop adds once the face store is full
        if (tri_count < FACE_DEPTH_DEF) begin
          tri_a[tri_count] = r.a;
          tri_b[tri_count] = r.b;
          tri_c[tri_count] = r.c;
          tri_key[tri_count] = corner_dist(r.a) + corner_dist(r.b) + corner_dist(r.c);
          tri_done[tri_count] = 1'b0;
          tri_count++;
        end
      end
      REQ_CLEAR: begin
        foreach (tri_done[i]) tri_done[i] = 1'b0;
        tri_count = 0;
        done_count = 0;
      end
      default: begin
        // farthest unreturned face wins; strict compare keeps ties in arrival order
        for (int i = 0; i < tri_count; i++) begin
          if (!tri_done[i] && (pick < 0 || tri_key[i] > tri_key[pick])) pick = i;
        end
        gives = 1'b1;
        if (pick < 0) begin
          res.none_left = 1'b1;
        end else begin
          tri_done[pick] = 1'b1;
          done_count++;
          res.face_number = pick[IDX_W-1:0];
          res.corner_a = tri_a[pick];
          res.corner_b = tri_b[pick];
          res.corner_c = tri_c[pick];
          res.key = tri_key[pick];
          res.is_final = (done_count >= tri_count);
        end
      end
    endcase
  endtask

  // Send one request, then record the face it should return
  task automatic send_req(input depth_req_t r, input bit typed, input face_result_t want);
    bit gives;
    face_result_t res;
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= r.kind;
    in_vertex_slot <= r.slot;
    in_pos_x <= r.x;
    in_pos_y <= r.y;
    in_pos_z <= r.z;
    in_corner_a <= r.a;
    in_corner_b <= r.b;
    in_corner_c <= r.c;
    do @(posedge clk); while (in_stall);
    sort_step(r, gives, res);
    if (gives) due_faces.push_back(typed ? want : res);
  endtask

  // Hold off requests until every returned face is in, then wait extra cycles
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (due_faces.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic put_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_camera(input logic [COORD_W-1:0] x, y, z);
    put_cfg(CFG_CAM_X, x);
    put_cfg(CFG_CAM_Y, y);
    put_cfg(CFG_CAM_Z, z);
    cfg_valid <= 1'b0;
    cam_x = x;
    cam_y = y;
    cam_z = z;
  endtask

  // Coordinate with extra weight on both extremes
  function automatic logic [COORD_W-1:0] any_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Random vertex slot among the first span written ones
  function automatic logic [IDX_W-1:0] known_slot(input int span);
    return vert_slots[$urandom_range(0, span - 1)];
  endfunction

  task automatic pick_request(output depth_req_t r);
    int roll;
    int span;
    r.slot = IDX_W'($urandom_range(0, 1023));
    r.x = any_coord();
    r.y = any_coord();
    r.z = any_coord();
    r.a = IDX_W'($urandom_range(0, 1023));
    r.b = IDX_W'($urandom_range(0, 1023));
    r.c = IDX_W'($urandom_range(0, 1023));
    roll = $urandom_range(0, 99);
    // drain a long list before growing it further
    if (tri_count >= 40) r.kind = (roll < 10) ? REQ_CLEAR : REQ_FETCH;
    else if (roll < 20) r.kind = REQ_LOAD;
    else if (roll < 58) r.kind = REQ_ADD;
    else if (roll < 96) r.kind = REQ_FETCH;
    else r.kind = REQ_CLEAR;
    if (r.kind == REQ_ADD) begin
      // few distinct corners give plenty of equal keys
      span = ($urandom_range(0, 3) == 0) ? 3 : vert_slots.size();
      r.a = known_slot(span);
      r.b = known_slot(span);
      r.c = known_slot(span);
    end
  endtask

  task automatic run_random(input int count);
    depth_req_t r;
    repeat (count) begin
      pick_request(r);
      send_req(r, 1'b0, '0);
      if ($urandom_range(0, 59) == 0) settle(0);
    end
  endtask

  // Compare one returned face with the oldest pending one
  always @(posedge clk) begin : watch_results
    face_result_t got;
    face_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_face_number, out_corner_a, out_corner_b, out_corner_c,
             out_distance_key, out_is_final, out_none_left};
      if (due_faces.size() == 0) begin
        flag($sformatf("unexpected result, face_number %0d", got.face_number));
      end else begin
        want = due_faces.pop_front();
        if (got.face_number !== want.face_number)
          flag($sformatf("face_number %0d, want %0d", got.face_number, want.face_number));
        if (got.corner_a !== want.corner_a)
          flag($sformatf("corner_a %0d, want %0d", got.corner_a, want.corner_a));
        if (got.corner_b !== want.corner_b)
          flag($sformatf("corner_b %0d, want %0d", got.corner_b, want.corner_b));
        if (got.corner_c !== want.corner_c)
          flag($sformatf("corner_c %0d, want %0d", got.corner_c, want.corner_c));
        if (got.key !== want.key)
          flag($sformatf("distance_key %0d, want %0d", got.key, want.key));
        if (got.is_final !== want.is_final)
          flag($sformatf("is_final %0b, want %0b", got.is_final, want.is_final));
        if (got.none_left !== want.none_left)
          flag($sformatf("none_left %0b, want %0b", got.none_left, want.none_left));
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    cam_x = '0;
    cam_y = '0;
    cam_z = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (script[i]) send_req(script[i].rq, script[i].typed, script[i].want);

    // Random traffic under three camera settings and idle mixes
    settle(32);
    write_camera(16'h7FFF, 16'h8000, 16'h7FFF);
    run_random(190);

    settle(32);
    send_gap_pct = 57;
    stall_pct = 13;
    write_camera(16'h8000, 16'h7FFF, 16'h8000);
    run_random(190);

    settle(32);
    send_gap_pct = 0;
    stall_pct = 0;
    write_camera(any_coord(), any_coord(), any_coord());
    run_random(190);

    settle(64);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
src/fds_pkg.sv
src/fds_ram.sv
src/fds_sq_acc.sv
src/face_depth_sorter.sv
sim/face_depth_sorter_tb.sv
